// File: sv/ptwa_pkg.sv
// Shared types, widths and codes for the peer table with aging.
`default_nettype none

package ptwa_pkg;

  localparam int unsigned MAX_PEERS_DEF = 16;

  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ENTRY_W  = IP_W + PORT_W + TIME_W;

  localparam int unsigned S_TDATA_W = ((IP_W + PORT_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((SLOT_W + 2 * COUNT_W + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(15);

  localparam logic [REQ_W-1:0] REQ_HELLO = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PURGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TICK      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PURGE     = 3'd4;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_HELLO,
    OP_TICK,
    OP_PURGE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_DONE,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

// File: sv/peer_table_with_aging.sv
// Peer table with aging: learns peers by IPv4 address and UDP port, refreshes
// their last-heard second on hello, advances the seconds counter on tick and
// removes stale peers on purge. Requests enter a two-deep queue and are carried
// out one at a time by a sequencer that reads one table slot per cycle from a
// single-write, single-read RAM. A tick needs no table walk; a hello or purge
// walks every slot, and each waits for the output to take its result. Valid
// bits are flip-flops cleared at reset, so no clearing pass is needed. Unused
// request codes are accepted and produce no response.
`default_nettype none

module peer_table_with_aging #(
  parameter int unsigned MAX_PEERS = ptwa_pkg::MAX_PEERS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ptwa_pkg::TIME_W-1:0]         cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [31:0] peer_ip, [47:32] peer_port
  input  wire logic [ptwa_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] req_type
  input  wire logic [ptwa_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [3:0] slot_index, [8:4] peer_count, [13:9] removed_count, rest zero
  output logic      [ptwa_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [2:0] status
  output logic      [ptwa_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
  localparam int unsigned RES_W = ptwa_pkg::SLOT_W + 2 * ptwa_pkg::COUNT_W;

  ptwa_pkg::qhead_t                  head;
  logic                              pop;
  logic                              ram_re;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [ptwa_pkg::ENTRY_W-1:0]      ram_rdata;
  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [ptwa_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [ptwa_pkg::SLOT_W-1:0]       res_slot;
  logic [ptwa_pkg::COUNT_W-1:0]      res_count;
  logic [ptwa_pkg::COUNT_W-1:0]      res_removed;

  ptwa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_type_i  (s_axis_tuser),
    .in_ip_i    (s_axis_tdata[ptwa_pkg::IP_W-1:0]),
    .in_port_i  (s_axis_tdata[ptwa_pkg::IP_W +: ptwa_pkg::PORT_W]),
    .head_o     (head),
    .pop_i      (pop)
  );

  ptwa_back #(
    .MAX_PEERS (MAX_PEERS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (head),
    .pop_o         (pop),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_status_o  (m_axis_tuser),
    .res_slot_o    (res_slot),
    .res_count_o   (res_count),
    .res_removed_o (res_removed)
  );

  ptwa_ram #(
    .WIDTH (ptwa_pkg::ENTRY_W),
    .DEPTH (MAX_PEERS),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {{(ptwa_pkg::M_TDATA_W - RES_W){1'b0}}, res_removed, res_count, res_slot};

endmodule

`default_nettype wire

// File: sv/ptwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/ptwa_front.sv
// Front end: decodes incoming requests, drops unused codes, queues the rest.
`default_nettype none

module ptwa_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ptwa_pkg::REQ_W-1:0]         in_type_i,
  input  wire logic [ptwa_pkg::IP_W-1:0]          in_ip_i,
  input  wire logic [ptwa_pkg::PORT_W-1:0]        in_port_i,
  output ptwa_pkg::qhead_t                        head_o,
  input  wire logic                               pop_i
);

  localparam logic [ptwa_pkg::QPTR_W-1:0] PTR_LAST = ptwa_pkg::QPTR_W'(ptwa_pkg::QDEPTH - 1);
  localparam logic [ptwa_pkg::QCNT_W-1:0] CNT_FULL = ptwa_pkg::QCNT_W'(ptwa_pkg::QDEPTH);

  ptwa_pkg::req_t                  mem_q [ptwa_pkg::QDEPTH];
  logic [ptwa_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ptwa_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ptwa_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  ptwa_pkg::req_t                  dec_req;
  logic                            dec_keep;
  logic                            push;
  logic                            pop;

  // Classify the request; an unused code is taken and dropped.
  always_comb begin
    dec_req.ip   = in_ip_i;
    dec_req.port = in_port_i;
    dec_req.op   = ptwa_pkg::OP_HELLO;
    dec_keep     = 1'b1;
    unique case (in_type_i)
      ptwa_pkg::REQ_HELLO: dec_req.op = ptwa_pkg::OP_HELLO;
      ptwa_pkg::REQ_TICK:  dec_req.op = ptwa_pkg::OP_TICK;
      ptwa_pkg::REQ_PURGE: dec_req.op = ptwa_pkg::OP_PURGE;
      default:             dec_keep   = 1'b0;
    endcase
  end

  assign in_ready_o   = (cnt_q != CNT_FULL);
  assign push         = in_valid_i && in_ready_o && dec_keep;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec_req;
    end
  end

endmodule

`default_nettype wire

// File: sv/ptwa_back.sv
// Back end: walks the peer table one slot a cycle to carry out a hello or purge; a tick needs no walk.
`default_nettype none

module ptwa_back #(
  parameter int unsigned MAX_PEERS = ptwa_pkg::MAX_PEERS_DEF,
  parameter int unsigned IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
  parameter int unsigned CNT_W     = $clog2(MAX_PEERS + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ptwa_pkg::TIME_W-1:0]        cfg_wdata_i,
  input  wire ptwa_pkg::qhead_t                   head_i,
  output logic                                    pop_o,
  output logic                                    ram_re_o,
  output logic      [IDX_W-1:0]                   ram_raddr_o,
  input  wire logic [ptwa_pkg::ENTRY_W-1:0]       ram_rdata_i,
  output logic                                    ram_we_o,
  output logic      [IDX_W-1:0]                   ram_waddr_o,
  output logic      [ptwa_pkg::ENTRY_W-1:0]       ram_wdata_o,
  output logic                                    res_valid_o,
  input  wire logic                               res_ready_i,
  output logic      [ptwa_pkg::STATUS_W-1:0]      res_status_o,
  output logic      [ptwa_pkg::SLOT_W-1:0]        res_slot_o,
  output logic      [ptwa_pkg::COUNT_W-1:0]       res_count_o,
  output logic      [ptwa_pkg::COUNT_W-1:0]       res_removed_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);

  ptwa_pkg::back_state_e            state_q, state_d;
  ptwa_pkg::req_t                   item_q, item_d;
  logic [IDX_W-1:0]                 rd_idx_q, rd_idx_d;
  logic                             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]                 cmp_idx_q, cmp_idx_d;
  logic                             hit_q, hit_d;
  logic [IDX_W-1:0]                 hit_slot_q, hit_slot_d;
  logic                             free_q, free_d;
  logic [IDX_W-1:0]                 free_slot_q, free_slot_d;
  logic [CNT_W-1:0]                 removed_q, removed_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [ptwa_pkg::TIME_W-1:0]      now_q, now_d;
  logic [ptwa_pkg::TIME_W-1:0]      timeout_q;
  logic [MAX_PEERS-1:0]             valid_q, valid_d;
  logic [ptwa_pkg::STATUS_W-1:0]    res_status_q, res_status_d;
  logic [IDX_W-1:0]                 res_slot_q, res_slot_d;

  logic [ptwa_pkg::IP_W-1:0]        rd_ip;
  logic [ptwa_pkg::PORT_W-1:0]      rd_port;
  logic [ptwa_pkg::TIME_W-1:0]      rd_last;
  logic [ptwa_pkg::TIME_W-1:0]      age;
  logic                             key_match;

  logic [ptwa_pkg::SLOT_W+IDX_W-1:0]    slot_ext;
  logic [ptwa_pkg::COUNT_W+CNT_W-1:0]   cnt_ext;
  logic [ptwa_pkg::COUNT_W+CNT_W-1:0]   removed_ext;

  assign rd_ip     = ram_rdata_i[ptwa_pkg::ENTRY_W-1 -: ptwa_pkg::IP_W];
  assign rd_port   = ram_rdata_i[ptwa_pkg::TIME_W +: ptwa_pkg::PORT_W];
  assign rd_last   = ram_rdata_i[ptwa_pkg::TIME_W-1:0];
  assign age       = now_q - rd_last;
  assign key_match = (rd_ip == item_q.ip) && (rd_port == item_q.port);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptwa_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          state_d = (head_i.req.op == ptwa_pkg::OP_TICK) ? ptwa_pkg::BK_OUT
                                                          : ptwa_pkg::BK_WALK;
        end
      end
      ptwa_pkg::BK_WALK: begin
        if (rd_idx_q == LAST_IDX) begin
          state_d = ptwa_pkg::BK_DRAIN;
        end
      end
      ptwa_pkg::BK_DRAIN: state_d = ptwa_pkg::BK_DONE;
      ptwa_pkg::BK_DONE:  state_d = ptwa_pkg::BK_OUT;
      ptwa_pkg::BK_OUT: begin
        if (res_ready_i) begin
          state_d = ptwa_pkg::BK_IDLE;
        end
      end
      default: state_d = ptwa_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o       = (state_q == ptwa_pkg::BK_IDLE) && head_i.valid;
    ram_re_o    = (state_q == ptwa_pkg::BK_WALK);
    ram_raddr_o = rd_idx_q;
    ram_we_o    = (state_q == ptwa_pkg::BK_DONE) && (item_q.op == ptwa_pkg::OP_HELLO) &&
                  (hit_q || free_q);
    ram_waddr_o = hit_q ? hit_slot_q : free_slot_q;
    ram_wdata_o = {item_q.ip, item_q.port, now_q};
    res_valid_o = (state_q == ptwa_pkg::BK_OUT);
  end

  // Datapath
  always_comb begin
    item_d       = item_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = (state_q == ptwa_pkg::BK_WALK);
    cmp_idx_d    = rd_idx_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    removed_d    = removed_q;
    cnt_d        = cnt_q;
    now_d        = now_q;
    valid_d      = valid_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;

    if ((state_q == ptwa_pkg::BK_IDLE) && head_i.valid) begin
      item_d     = head_i.req;
      rd_idx_d   = '0;
      hit_d      = 1'b0;
      free_d     = 1'b0;
      removed_d  = '0;
      res_slot_d = '0;
      if (head_i.req.op == ptwa_pkg::OP_TICK) begin
        now_d        = now_q + 1'b1;
        res_status_d = ptwa_pkg::ST_TICK;
      end
    end

    if (state_q == ptwa_pkg::BK_WALK) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end

    // Compare stage: one slot's data arrives each cycle behind the read.
    if (cmp_vld_q) begin
      if (item_q.op == ptwa_pkg::OP_HELLO) begin
        if (valid_q[cmp_idx_q]) begin
          if (!hit_q && key_match) begin
            hit_d      = 1'b1;
            hit_slot_d = cmp_idx_q;
          end
        end else if (!free_q) begin
          free_d      = 1'b1;
          free_slot_d = cmp_idx_q;
        end
      end else if (item_q.op == ptwa_pkg::OP_PURGE) begin
        if (valid_q[cmp_idx_q] && (age > timeout_q)) begin
          valid_d[cmp_idx_q] = 1'b0;
          removed_d          = removed_q + 1'b1;
          cnt_d              = cnt_q - 1'b1;
        end
      end
    end

    if (state_q == ptwa_pkg::BK_DONE) begin
      if (item_q.op == ptwa_pkg::OP_HELLO) begin
        if (hit_q) begin
          res_status_d = ptwa_pkg::ST_REFRESHED;
          res_slot_d   = hit_slot_q;
        end else if (free_q) begin
          res_status_d         = ptwa_pkg::ST_ADDED;
          res_slot_d           = free_slot_q;
          valid_d[free_slot_q] = 1'b1;
          cnt_d                = cnt_q + 1'b1;
        end else begin
          res_status_d = ptwa_pkg::ST_FULL;
          res_slot_d   = '0;
        end
      end else begin
        res_status_d = ptwa_pkg::ST_PURGE;
        res_slot_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptwa_pkg::BK_IDLE;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      removed_q <= '0;
      cnt_q     <= '0;
      now_q     <= '0;
      timeout_q <= ptwa_pkg::TIMEOUT_RST;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      removed_q <= removed_d;
      cnt_q     <= cnt_d;
      now_q     <= now_d;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_slot_q   <= hit_slot_d;
    free_slot_q  <= free_slot_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  // Report fields are cut to their fixed widths.
  assign slot_ext      = {{ptwa_pkg::SLOT_W{1'b0}}, res_slot_q};
  assign cnt_ext       = {{ptwa_pkg::COUNT_W{1'b0}}, cnt_q};
  assign removed_ext   = {{ptwa_pkg::COUNT_W{1'b0}}, removed_q};
  assign res_status_o  = res_status_q;
  assign res_slot_o    = slot_ext[ptwa_pkg::SLOT_W-1:0];
  assign res_count_o   = cnt_ext[ptwa_pkg::COUNT_W-1:0];
  assign res_removed_o = removed_ext[ptwa_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire
